// File: rtl/rotr_pkg.sv
package rotr_pkg;

    localparam int SAMPLE_W = 12;
    localparam int BYTE_W   = 8;
    localparam int RMS_W    = 12;
    localparam int THRESH_W = 10;
    localparam int HEAT_W   = 16;
    localparam int SQUARE_W = 2 * SAMPLE_W;
    localparam int LHS_W    = 25;
    localparam int TMUL_W   = 18;

    localparam logic [BYTE_W-1:0] CMD_CLOSE = 8'h30;
    localparam logic [BYTE_W-1:0] CMD_OPEN  = 8'h31;
    localparam logic [BYTE_W-1:0] CMD_RAISE = 8'h32;
    localparam logic [BYTE_W-1:0] CMD_LOWER = 8'h33;

    localparam logic [THRESH_W-1:0] THRESH_MAX       = 10'd1000;
    localparam logic [THRESH_W-1:0] THRESH_RESET     = 10'd40;
    localparam logic [HEAT_W-1:0]   HEAT_LIMIT_RESET = 16'd500;
    localparam logic [HEAT_W-1:0]   HEAT_MAX         = 16'hFFFF;
    localparam logic [HEAT_W-1:0]   COOL_LOW         = 16'd20;
    localparam logic [HEAT_W-1:0]   COOL_MID         = 16'd10;
    localparam logic [HEAT_W-1:0]   HEAT_RISE        = 16'd5;

    localparam logic [LHS_W-1:0]  RMS_SCALE = 25'd6600;
    localparam logic [TMUL_W-1:0] ZONE1_MUL = 18'd90;
    localparam logic [TMUL_W-1:0] ZONE2_MUL = 18'd115;
    localparam logic [TMUL_W-1:0] ZONE3_MUL = 18'd180;

    typedef enum logic [2:0] {
        TOP_IDLE,
        TOP_WAIT,
        TOP_ZMUL,
        TOP_ZCMP,
        TOP_EMIT
    } rotr_state_t;

    typedef enum logic [1:0] {
        RMS_IDLE,
        RMS_SQUARE,
        RMS_DIVIDE,
        RMS_ROOT
    } rotr_rms_state_t;

    typedef struct packed {
        logic finish;
        logic window;
    } rotr_rms_status_t;

endpackage

// File: rtl/rms_overcurrent_thermal_trip.sv
// RMS overcurrent relay with thermal accumulator and remote commands.
// Input words on s_: s_tuser selects an ADC sample (0) or a command byte (1).
// Every input word yields exactly one result word on m_ carrying relay drive,
// warning LED, latest window RMS, threshold, heat level and, on m_tuser, a
// flag marking the sample that closed a window and ran the zone logic.
// heat_limit is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while idle, as the block itself does not enforce this.
// A sample runs through the serial squarer, one multiplier bit per cycle. A
// window-closing sample then adds bit-serial division of the SUM_W-bit sum by
// WINDOW_SAMPLES (SUM_W = 24 + clog2(WINDOW_SAMPLES), 30 by default), a
// two-bit-per-cycle square root and zone evaluation (TOP_ZMUL, then TOP_ZCMP).
// One word is in flight at a time; the next word can be accepted in the cycle
// after the result register loads.
// s_tready is high whenever the core is idle, even while a result waits on m_.
// If m_tready is low when the next result is ready, the core holds in its
// emit state until the output register frees up.
// Reset: threshold 4.0 A, heat 0, relay closed, LED off, RMS 0, heat_limit 500,
// partial window cleared, no result pending.
module rms_overcurrent_thermal_trip #(
    parameter int WINDOW_SAMPLES = 50,
    parameter int ADC_BITS       = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // heat_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // sample[11:0], rx_byte[19:12], zero pad
    input  logic [0:0]  s_tuser,       // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // relay_closed, warn_led, rms_code[13:2],
                                       // threshold_now[23:14], heat_level[39:24]
    output logic [0:0]  m_tuser        // window_done
);

    localparam int CMP_W = rotr_pkg::TMUL_W + ADC_BITS;

    rotr_pkg::rotr_state_t state_reg, state_next;

    logic [rotr_pkg::THRESH_W-1:0] thresh_reg, thresh_next;
    logic [rotr_pkg::HEAT_W-1:0]   heat_reg, heat_next;
    logic [rotr_pkg::HEAT_W-1:0]   heat_limit_reg;
    logic                          relay_reg, relay_next;
    logic                          led_reg, led_next;
    logic                          done_reg, done_next;
    logic [rotr_pkg::LHS_W-1:0]    lhs_reg, lhs_next;
    logic [rotr_pkg::TMUL_W-1:0]   t1_reg, t1_next, t2_reg, t2_next, t3_reg, t3_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [39:0]                   m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;

    logic                          s_accept, rms_start, load_out;
    logic [rotr_pkg::BYTE_W-1:0]   rx_byte;
    rotr_pkg::rotr_rms_status_t    rms_status;
    logic [rotr_pkg::RMS_W-1:0]    rms_code;
    logic [CMP_W-1:0]              lhs_ext;
    logic                          zone1, zone2, zone3, zone_open;
    logic [rotr_pkg::HEAT_W:0]     heat_rise;
    logic [rotr_pkg::HEAT_W-1:0]   heat_hot;

    assign rx_byte   = s_tdata[19:12];
    assign s_accept  = s_tvalid && s_tready;

    rotr_rms_unit #(
        .WINDOW_SAMPLES(WINDOW_SAMPLES)
    ) u_rms (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rms_start),
        .sample  (s_tdata[rotr_pkg::SAMPLE_W-1:0]),
        .status  (rms_status),
        .rms     (rms_code)
    );

    assign lhs_ext   = CMP_W'(lhs_reg);
    assign zone1     = lhs_ext < (CMP_W'(t1_reg) << ADC_BITS);
    assign zone2     = lhs_ext < (CMP_W'(t2_reg) << ADC_BITS);
    assign zone3     = lhs_ext < (CMP_W'(t3_reg) << ADC_BITS);
    assign zone_open = !zone3;
    assign heat_rise = {1'b0, heat_reg} + {1'b0, rotr_pkg::HEAT_RISE};
    assign heat_hot  = heat_rise[rotr_pkg::HEAT_W] ? rotr_pkg::HEAT_MAX
                                                   : heat_rise[rotr_pkg::HEAT_W-1:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rotr_pkg::TOP_IDLE: begin
                if (s_accept) begin
                    state_next = s_tuser[0] ? rotr_pkg::TOP_EMIT : rotr_pkg::TOP_WAIT;
                end
            end
            rotr_pkg::TOP_WAIT: begin
                if (rms_status.finish) begin
                    state_next = rms_status.window ? rotr_pkg::TOP_ZMUL : rotr_pkg::TOP_EMIT;
                end
            end
            rotr_pkg::TOP_ZMUL: begin
                state_next = rotr_pkg::TOP_ZCMP;
            end
            rotr_pkg::TOP_ZCMP: begin
                state_next = rotr_pkg::TOP_EMIT;
            end
            rotr_pkg::TOP_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = rotr_pkg::TOP_IDLE;
                end
            end
            default: begin
                state_next = rotr_pkg::TOP_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == rotr_pkg::TOP_IDLE);
        rms_start = (state_reg == rotr_pkg::TOP_IDLE) && s_tvalid && !s_tuser[0];
        load_out  = (state_reg == rotr_pkg::TOP_EMIT) && (!m_tvalid_reg || m_tready);
    end

    always_comb begin
        thresh_next   = thresh_reg;
        heat_next     = heat_reg;
        relay_next    = relay_reg;
        led_next      = led_reg;
        done_next     = done_reg;
        lhs_next      = lhs_reg;
        t1_next       = t1_reg;
        t2_next       = t2_reg;
        t3_next       = t3_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        case (state_reg)
            rotr_pkg::TOP_IDLE: begin
                done_next = 1'b0;
                if (s_accept && s_tuser[0]) begin
                    case (rx_byte)
                        rotr_pkg::CMD_CLOSE: relay_next = 1'b1;
                        rotr_pkg::CMD_OPEN:  relay_next = 1'b0;
                        rotr_pkg::CMD_RAISE: begin
                            if (thresh_reg < rotr_pkg::THRESH_MAX) begin
                                thresh_next = thresh_reg + 1'b1;
                            end
                        end
                        rotr_pkg::CMD_LOWER: begin
                            if (thresh_reg != '0) begin
                                thresh_next = thresh_reg - 1'b1;
                            end
                        end
                        default: relay_next = relay_reg;
                    endcase
                end
            end
            rotr_pkg::TOP_ZMUL: begin
                lhs_next = rotr_pkg::LHS_W'(rms_code) * rotr_pkg::RMS_SCALE;
                t1_next  = rotr_pkg::TMUL_W'(thresh_reg) * rotr_pkg::ZONE1_MUL;
                t2_next  = rotr_pkg::TMUL_W'(thresh_reg) * rotr_pkg::ZONE2_MUL;
                t3_next  = rotr_pkg::TMUL_W'(thresh_reg) * rotr_pkg::ZONE3_MUL;
            end
            rotr_pkg::TOP_ZCMP: begin
                done_next = 1'b1;
                if (zone1) begin
                    led_next  = 1'b0;
                    heat_next = (heat_reg > rotr_pkg::COOL_LOW)
                              ? heat_reg - rotr_pkg::COOL_LOW : '0;
                end else if (zone2) begin
                    led_next  = 1'b1;
                    heat_next = (heat_reg > rotr_pkg::COOL_MID)
                              ? heat_reg - rotr_pkg::COOL_MID : '0;
                end else if (zone3) begin
                    heat_next = heat_hot;
                    if (heat_hot >= heat_limit_reg) begin
                        relay_next = 1'b0;
                    end
                end else begin
                    relay_next = 1'b0;
                end
            end
            rotr_pkg::TOP_EMIT: begin
                if (load_out) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {heat_reg, thresh_reg, rms_code, led_reg, relay_reg};
                    m_tuser_next  = done_reg;
                end
            end
            default: begin
                done_next = done_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rotr_pkg::TOP_IDLE;
            thresh_reg     <= rotr_pkg::THRESH_RESET;
            heat_reg       <= '0;
            heat_limit_reg <= rotr_pkg::HEAT_LIMIT_RESET;
            relay_reg      <= 1'b1;
            led_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            thresh_reg   <= thresh_next;
            heat_reg     <= heat_next;
            relay_reg    <= relay_next;
            led_reg      <= led_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                heat_limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        done_reg    <= done_next;
        lhs_reg     <= lhs_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        t3_reg      <= t3_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_thresh_range: assert property (@(posedge aclk) disable iff (!aresetn)
        thresh_reg <= rotr_pkg::THRESH_MAX)
        else $error("threshold above limit");

    a_finish_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        rms_status.finish |-> state_reg == rotr_pkg::TOP_WAIT)
        else $error("rms unit finished outside wait state");

    a_zone_open_trips: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rotr_pkg::TOP_ZCMP && zone_open) |=> !relay_reg)
        else $error("relay not opened in top zone");

    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rotr_pkg::TOP_EMIT && m_tvalid_reg && !m_tready)
        |=> state_reg == rotr_pkg::TOP_EMIT)
        else $error("result emitted over a pending word");

endmodule

// File: rtl/rotr_rms_unit.sv
module rotr_rms_unit #(
    parameter int WINDOW_SAMPLES = 50
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [rotr_pkg::SAMPLE_W-1:0]   sample,
    output rotr_pkg::rotr_rms_status_t      status,
    output logic [rotr_pkg::RMS_W-1:0]      rms
);

    localparam int SUM_W  = rotr_pkg::SQUARE_W + $clog2(WINDOW_SAMPLES);
    localparam int CNT_W  = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
    localparam int DREM_W = $clog2(WINDOW_SAMPLES) + 1;
    localparam int STEP_W = $clog2(SUM_W);
    localparam int RREM_W = rotr_pkg::RMS_W + 2;

    rotr_pkg::rotr_rms_state_t state_reg, state_next;

    logic [SUM_W-1:0]                  sum_reg, sum_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [rotr_pkg::SQUARE_W-1:0]     mcand_reg, mcand_next;
    logic [rotr_pkg::SAMPLE_W-1:0]     mplier_reg, mplier_next;
    logic [DREM_W-1:0]                 drem_reg, drem_next;
    logic [STEP_W-1:0]                 step_reg, step_next;
    logic [rotr_pkg::RMS_W-1:0]        root_reg, root_next;
    logic [RREM_W-1:0]                 rrem_reg, rrem_next;
    logic [rotr_pkg::RMS_W-1:0]        rms_reg, rms_next;
    logic                              window_reg, window_next;
    logic                              finish_reg, finish_next;

    logic                              last_square, last_divide, last_root;
    logic [DREM_W:0]                   div_shift, div_diff;
    logic                              div_ge;
    logic [RREM_W+1:0]                 root_shift, root_trial, root_diff;
    logic                              root_ge;
    logic [rotr_pkg::RMS_W-1:0]        root_step;

    assign last_square = (step_reg == STEP_W'(rotr_pkg::SAMPLE_W - 1));
    assign last_divide = (step_reg == STEP_W'(SUM_W - 1));
    assign last_root   = (step_reg == STEP_W'(rotr_pkg::RMS_W - 1));

    assign div_shift = {drem_reg, sum_reg[SUM_W-1]};
    assign div_ge    = (div_shift >= (DREM_W+1)'(WINDOW_SAMPLES));
    assign div_diff  = div_shift - (DREM_W+1)'(WINDOW_SAMPLES);

    assign root_shift = {rrem_reg, sum_reg[rotr_pkg::SQUARE_W-1 -: 2]};
    assign root_trial = (RREM_W+2)'({root_reg, 2'b01});
    assign root_ge    = (root_shift >= root_trial);
    assign root_diff  = root_shift - root_trial;
    assign root_step  = {root_reg[rotr_pkg::RMS_W-2:0], root_ge};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rotr_pkg::RMS_IDLE: begin
                if (start) begin
                    state_next = rotr_pkg::RMS_SQUARE;
                end
            end
            rotr_pkg::RMS_SQUARE: begin
                if (last_square) begin
                    state_next = window_reg ? rotr_pkg::RMS_DIVIDE : rotr_pkg::RMS_IDLE;
                end
            end
            rotr_pkg::RMS_DIVIDE: begin
                if (last_divide) begin
                    state_next = rotr_pkg::RMS_ROOT;
                end
            end
            rotr_pkg::RMS_ROOT: begin
                if (last_root) begin
                    state_next = rotr_pkg::RMS_IDLE;
                end
            end
            default: begin
                state_next = rotr_pkg::RMS_IDLE;
            end
        endcase
    end

    always_comb begin
        sum_next    = sum_reg;
        count_next  = count_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        drem_next   = drem_reg;
        step_next   = step_reg;
        root_next   = root_reg;
        rrem_next   = rrem_reg;
        rms_next    = rms_reg;
        window_next = window_reg;
        finish_next = 1'b0;
        case (state_reg)
            rotr_pkg::RMS_IDLE: begin
                if (start) begin
                    mcand_next  = rotr_pkg::SQUARE_W'(sample);
                    mplier_next = sample;
                    step_next   = '0;
                    window_next = (count_reg == CNT_W'(WINDOW_SAMPLES - 1));
                    count_next  = window_next ? '0 : count_reg + 1'b1;
                end
            end
            rotr_pkg::RMS_SQUARE: begin
                if (mplier_reg[0]) begin
                    sum_next = sum_reg + SUM_W'(mcand_reg);
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg + 1'b1;
                if (last_square) begin
                    step_next   = '0;
                    drem_next   = '0;
                    finish_next = !window_reg;
                end
            end
            rotr_pkg::RMS_DIVIDE: begin
                sum_next  = {sum_reg[SUM_W-2:0], div_ge};
                drem_next = div_ge ? div_diff[DREM_W-1:0] : div_shift[DREM_W-1:0];
                step_next = step_reg + 1'b1;
                if (last_divide) begin
                    step_next = '0;
                    root_next = '0;
                    rrem_next = '0;
                end
            end
            rotr_pkg::RMS_ROOT: begin
                sum_next  = sum_reg << 2;
                root_next = root_step;
                rrem_next = root_ge ? root_diff[RREM_W-1:0] : root_shift[RREM_W-1:0];
                step_next = step_reg + 1'b1;
                if (last_root) begin
                    sum_next    = '0;
                    rms_next    = root_step;
                    finish_next = 1'b1;
                end
            end
            default: begin
                finish_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= rotr_pkg::RMS_IDLE;
            sum_reg    <= '0;
            count_reg  <= '0;
            rms_reg    <= '0;
            window_reg <= 1'b0;
            finish_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            rms_reg    <= rms_next;
            window_reg <= window_next;
            finish_reg <= finish_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        drem_reg   <= drem_next;
        step_reg   <= step_next;
        root_reg   <= root_next;
        rrem_reg   <= rrem_next;
    end

    assign status.finish = finish_reg;
    assign status.window = window_reg;
    assign rms           = rms_reg;

endmodule
